// ===== rtl/imsu_pkg.sv =====
// ---------------------------------------------------------------------------
// imsu_pkg
// Shared widths, field positions, codes and types of the spin update unit.
// ---------------------------------------------------------------------------
package imsu_pkg;

  localparam int SIDE_DEFAULT = 8;
  localparam int SITE_W       = 6;
  localparam int FRAC_W       = 16;
  localparam int LIMIT_W      = 16;
  localparam int DE_W         = 5;
  localparam int OFFSET_W     = 10;
  localparam int QUEUE_DEPTH  = 2;

  // Input item layout in s_tdata, lowest bit first.
  localparam int IN_SITE_LSB   = 0;
  localparam int IN_SPIN_BIT   = IN_SITE_LSB + SITE_W;
  localparam int IN_BDOWN_BIT  = IN_SPIN_BIT + 1;
  localparam int IN_BRIGHT_BIT = IN_BDOWN_BIT + 1;
  localparam int IN_FRAC_LSB   = IN_BRIGHT_BIT + 1;
  localparam int IN_BITS       = IN_FRAC_LSB + FRAC_W;
  localparam int S_TDATA_W     = ((IN_BITS + 7) / 8) * 8;

  // Result item layout in m_tdata, lowest bit first.
  localparam int OUT_FLIP_BIT = 0;
  localparam int OUT_DE_LSB   = OUT_FLIP_BIT + 1;
  localparam int OUT_SPIN_BIT = OUT_DE_LSB + DE_W;
  localparam int OUT_OFS_LSB  = OUT_SPIN_BIT + 1;
  localparam int OUT_BITS     = OUT_OFS_LSB + OFFSET_W;
  localparam int M_TDATA_W    = ((OUT_BITS + 7) / 8) * 8;

  // Item kinds carried in s_tuser.
  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_ATTEMPT = 1'b1;

  // Configuration register indexes.
  localparam int   CFG_IDX_W     = 1;
  localparam logic CFG_LIMIT_DE4 = 1'b0;
  localparam logic CFG_LIMIT_DE8 = 1'b1;

  // Energy rise that uses the small threshold.
  localparam logic signed [DE_W-1:0] DE_RISE_SMALL = 5'sd4;

  typedef struct packed {
    logic              attempt;
    logic              in_range;
    logic              spin_up;
    logic              bond_down;
    logic              bond_right;
    logic [FRAC_W-1:0] frac;
  } cmd_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] limit_de4;
    logic [LIMIT_W-1:0] limit_de8;
  } cfg_t;

endpackage

// ===== rtl/imsu_queue.sv =====
// ---------------------------------------------------------------------------
// imsu_queue
// Small first-in first-out buffer between the front and back parts.
// ---------------------------------------------------------------------------
module imsu_queue #(
  parameter int WIDTH = 1,
  parameter int DEPTH = imsu_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/imsu_front.sv =====
// ---------------------------------------------------------------------------
// imsu_front
// Takes input items, classifies them and splits the site into row and column.
// ---------------------------------------------------------------------------
module imsu_front #(
  parameter int SIDE = imsu_pkg::SIDE_DEFAULT
) (
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [imsu_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic                           s_tuser,
  output logic                           push_valid,
  input  logic                           push_ready,
  output imsu_pkg::cmd_t                 push_cmd,
  output logic [$clog2(SIDE)-1:0]        push_row,
  output logic [$clog2(SIDE)-1:0]        push_col
);
  import imsu_pkg::*;

  localparam int IDX_W       = $clog2(SIDE);
  localparam int SITES       = SIDE * SIDE;
  localparam int RECIP_SHIFT = 2 * SITE_W;
  localparam int RECIP       = ((1 << RECIP_SHIFT) + SIDE - 1) / SIDE;
  localparam int PROD_W      = SITE_W + RECIP_SHIFT;

  logic [SITE_W-1:0] site;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] row_full;
  logic [PROD_W-1:0] row_base;
  logic [SITE_W-1:0] col_full;

  assign site = s_tdata[IN_SITE_LSB +: SITE_W];

  // Row is site divided by SIDE through a scaled reciprocal; the error term
  // stays below one part in SIDE for six-bit sites, so the floor is exact.
  always_comb begin
    prod     = PROD_W'(site) * PROD_W'(RECIP);
    row_full = prod >> RECIP_SHIFT;
    row_base = row_full * PROD_W'(SIDE);
    col_full = site - row_base[SITE_W-1:0];
  end

  assign s_tready   = push_ready;
  assign push_valid = s_tvalid;
  assign push_row   = row_full[IDX_W-1:0];
  assign push_col   = col_full[IDX_W-1:0];

  always_comb begin
    push_cmd.attempt    = (s_tuser == KIND_ATTEMPT);
    push_cmd.in_range   = (32'(site) < 32'(SITES));
    push_cmd.spin_up    = s_tdata[IN_SPIN_BIT];
    push_cmd.bond_down  = s_tdata[IN_BDOWN_BIT];
    push_cmd.bond_right = s_tdata[IN_BRIGHT_BIT];
    push_cmd.frac       = s_tdata[IN_FRAC_LSB +: FRAC_W];
  end

endmodule

// ===== rtl/imsu_back.sv =====
// ---------------------------------------------------------------------------
// imsu_back
// Lattice memories, neighbor read sequencer, Metropolis decision and result.
// ---------------------------------------------------------------------------
module imsu_back #(
  parameter int SIDE = imsu_pkg::SIDE_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  imsu_pkg::cfg_t                 cfg,
  input  logic                           pop_valid,
  output logic                           pop_ready,
  input  imsu_pkg::cmd_t                 pop_cmd,
  input  logic [$clog2(SIDE)-1:0]        pop_row,
  input  logic [$clog2(SIDE)-1:0]        pop_col,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [imsu_pkg::M_TDATA_W-1:0] m_tdata
);
  import imsu_pkg::*;

  localparam int IDX_W = $clog2(SIDE);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_RD_UP  = 3'd1;
  localparam logic [2:0] ST_RD_DN  = 3'd2;
  localparam logic [2:0] ST_EVAL   = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  // One word per lattice row for spins, down bonds and right bonds.
  logic [SIDE-1:0] spin_mem  [SIDE];
  logic [SIDE-1:0] down_mem  [SIDE];
  logic [SIDE-1:0] right_mem [SIDE];
  logic [SIDE-1:0] rd_spin;
  logic [SIDE-1:0] rd_down;
  logic [SIDE-1:0] rd_right;

  logic [2:0]       state;
  logic [2:0]       state_next;
  cmd_t             cmd;
  logic [IDX_W-1:0] row;
  logic [IDX_W-1:0] col;
  logic [IDX_W-1:0] up;
  logic [IDX_W-1:0] dn;
  logic [IDX_W-1:0] lf;
  logic [IDX_W-1:0] rt;
  logic [IDX_W-1:0] rd_addr;

  logic s_c, d_own, r_own, r_lf, s_lf, s_rt, b_up, s_up;
  logic t_up, t_dn, t_lf, t_rt;
  logic [2:0] ones;
  logic signed [DE_W-1:0] de;
  logic signed [DE_W-1:0] de_next;

  logic                commit;
  logic                is_flip;
  logic                above_limit;
  logic                spin_after;
  logic [OFFSET_W-1:0] energy_sum;
  logic [OFFSET_W-1:0] energy_sum_next;
  logic                out_valid;

  assign up = (row == '0) ? IDX_W'(SIDE - 1) : row - IDX_W'(1);
  assign dn = (row == IDX_W'(SIDE - 1)) ? '0 : row + IDX_W'(1);
  assign lf = (col == '0) ? IDX_W'(SIDE - 1) : col - IDX_W'(1);
  assign rt = (col == IDX_W'(SIDE - 1)) ? '0 : col + IDX_W'(1);

  assign pop_ready = (state == ST_IDLE);
  assign commit    = (state == ST_FINISH) && (!out_valid || m_tready);

  always_comb begin
    case (state)
      ST_IDLE:  rd_addr = pop_row;
      ST_RD_UP: rd_addr = up;
      ST_RD_DN: rd_addr = dn;
      default:  rd_addr = row;
    endcase
  end

  // Lattice memory: one registered row read and one site write per cycle.
  always_ff @(posedge clk) begin
    rd_spin  <= spin_mem[rd_addr];
    rd_down  <= down_mem[rd_addr];
    rd_right <= right_mem[rd_addr];
    if (commit && cmd.in_range) begin
      if (!cmd.attempt) begin
        spin_mem[row][col]  <= cmd.spin_up;
        down_mem[row][col]  <= cmd.bond_down;
        right_mem[row][col] <= cmd.bond_right;
      end else if (is_flip) begin
        spin_mem[row][col] <= ~s_c;
      end
    end
  end

  // Each term is +1 when the xor of bond, spin and neighbor is set, so
  // dE = 8 - 4 * (number of set terms).
  always_comb begin
    t_up    = b_up ^ s_c ^ s_up;
    t_dn    = d_own ^ s_c ^ rd_spin[col];
    t_lf    = r_lf ^ s_c ^ s_lf;
    t_rt    = r_own ^ s_c ^ s_rt;
    ones    = 3'(t_up) + 3'(t_dn) + 3'(t_lf) + 3'(t_rt);
    de_next = DE_W'(8) - DE_W'({ones, 2'b00});
  end

  always_comb begin
    if (de == DE_RISE_SMALL) begin
      above_limit = (cmd.frac > cfg.limit_de4);
    end else begin
      above_limit = (cmd.frac > cfg.limit_de8);
    end
    is_flip = cmd.attempt && cmd.in_range && (de <= 0 || !above_limit);
    if (!cmd.in_range) begin
      spin_after = 1'b0;
    end else if (!cmd.attempt) begin
      spin_after = cmd.spin_up;
    end else begin
      spin_after = s_c ^ is_flip;
    end
    energy_sum_next = energy_sum;
    if (is_flip) begin
      energy_sum_next = energy_sum + {{(OFFSET_W - DE_W){de[DE_W-1]}}, de};
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (pop_valid) begin
          state_next = (pop_cmd.attempt && pop_cmd.in_range) ? ST_RD_UP : ST_FINISH;
        end
      end
      ST_RD_UP:  state_next = ST_RD_DN;
      ST_RD_DN:  state_next = ST_EVAL;
      ST_EVAL:   state_next = ST_FINISH;
      ST_FINISH: state_next = commit ? ST_IDLE : ST_FINISH;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (pop_valid) begin
          cmd <= pop_cmd;
          row <= pop_row;
          col <= pop_col;
          de  <= '0;
        end
      end
      ST_RD_UP: begin
        s_c   <= rd_spin[col];
        d_own <= rd_down[col];
        r_own <= rd_right[col];
        r_lf  <= rd_right[lf];
        s_lf  <= rd_spin[lf];
        s_rt  <= rd_spin[rt];
      end
      ST_RD_DN: begin
        b_up <= rd_down[col];
        s_up <= rd_spin[col];
      end
      ST_EVAL: begin
        de <= de_next;
      end
      default: begin
      end
    endcase
    if (commit) begin
      m_tdata <= M_TDATA_W'({energy_sum_next, spin_after, de, is_flip});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      energy_sum <= '0;
    end else begin
      state <= state_next;
      if (commit) begin
        out_valid  <= 1'b1;
        energy_sum <= energy_sum_next;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;

endmodule

// ===== rtl/ising_metropolis_spin_update_unit.sv =====
// ---------------------------------------------------------------------------
// ising_metropolis_spin_update_unit
// Metropolis single-spin update for a two-dimensional Ising spin glass.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Handshake          Contents
//  s_*       in         s_tvalid/s_tready  load or flip attempt item
//  m_*       out        m_tvalid/m_tready  one result item per input item
//  cfg_*     in         cfg_we             acceptance thresholds
//
// Attempts on in-range sites pass up-read, down-read and evaluate states, which
// loads skip; the lattice is held as row words in single-read-port memories, and
// an attempt reads its own row, the row above and the row below, one row per cycle.
// The front end accepts an item in any cycle where its two-entry queue has
// room, so items are taken while a finished result waits on m_tready.
// Synchronous rst clears the queue, the sequencer, the output valid flag, the
// energy offset and both thresholds; the lattice memories are not cleared and
// every site must be loaded before an attempt reads it.
// A stalled m_tready holds the result; the back end then waits and the queue
// fills until s_tready drops.
//
module ising_metropolis_spin_update_unit #(
  parameter int SIDE = imsu_pkg::SIDE_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration writes.
  input  logic                            cfg_we,
  input  logic [imsu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [imsu_pkg::LIMIT_W-1:0]    cfg_data,
  // Input items.
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // site[5:0], spin_up[6], bond_down_pos[7], bond_right_pos[8],
  // random_fraction[24:9], zero fill above.
  input  logic [imsu_pkg::S_TDATA_W-1:0]  s_tdata,
  // kind: 0 load, 1 attempt.
  input  logic                            s_tuser,
  // Result items.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // flipped[0], energy_change[5:1], spin_after[6], energy_offset[16:7],
  // zero fill above.
  output logic [imsu_pkg::M_TDATA_W-1:0]  m_tdata
);
  import imsu_pkg::*;

  localparam int IDX_W = $clog2(SIDE);
  localparam int Q_W   = $bits(cmd_t) + 2 * IDX_W;

  cfg_t             cfg;
  logic             push_valid;
  logic             push_ready;
  cmd_t             push_cmd;
  logic [IDX_W-1:0] push_row;
  logic [IDX_W-1:0] push_col;
  logic             pop_valid;
  logic             pop_ready;
  logic [Q_W-1:0]   pop_data;
  cmd_t             pop_cmd;
  logic [IDX_W-1:0] pop_row;
  logic [IDX_W-1:0] pop_col;

  // Threshold registers, to be written by the user only while the unit is idle; the block has no check for it.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LIMIT_DE4: cfg.limit_de4 <= cfg_data;
        CFG_LIMIT_DE8: cfg.limit_de8 <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The front end decodes the item and works out the lattice row and column.
  imsu_front #(.SIDE(SIDE)) u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .push_row   (push_row),
    .push_col   (push_col)
  );

  // The queue lets the front keep taking items while the back end reads.
  imsu_queue #(.WIDTH(Q_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_cmd, push_row, push_col}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign pop_cmd = pop_data[Q_W-1 -: $bits(cmd_t)];
  assign pop_row = pop_data[2*IDX_W-1 -: IDX_W];
  assign pop_col = pop_data[IDX_W-1:0];

  // The back end reads the neighbors, decides the flip and holds the result.
  imsu_back #(.SIDE(SIDE)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .pop_row   (pop_row),
    .pop_col   (pop_col),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

// ===== rtl/imsu_checker.sv =====
// ---------------------------------------------------------------------------
// imsu_checker
// Port-level checks of the spin update unit, bound to the top level.
// ---------------------------------------------------------------------------
module imsu_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [imsu_pkg::M_TDATA_W-1:0]  m_tdata
);
  import imsu_pkg::*;

  logic [OFFSET_W-1:0] last_offset;
  logic [OFFSET_W-1:0] expect_offset;
  logic [DE_W-1:0]     de_bits;
  logic                flip_bit;

  assign de_bits  = m_tdata[OUT_DE_LSB +: DE_W];
  assign flip_bit = m_tdata[OUT_FLIP_BIT];
  assign expect_offset = flip_bit ?
      last_offset + {{(OFFSET_W - DE_W){de_bits[DE_W-1]}}, de_bits} : last_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_offset <= '0;
    end else if (m_tvalid && m_tready) begin
      last_offset <= m_tdata[OUT_OFS_LSB +: OFFSET_W];
    end
  end

  // A stalled result keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // The energy change is always a multiple of four between -8 and 8.
  a_de_form: assert property (@(posedge clk) disable iff (rst)
      m_tvalid |-> de_bits[1:0] == 2'b00 && de_bits[4:2] != 3'b011 &&
                   de_bits[4:2] != 3'b100 && de_bits[4:2] != 3'b101)
    else $error("energy change out of range");

  // An energy drop is always accepted.
  a_drop_flips: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && de_bits[DE_W-1] |-> flip_bit)
    else $error("energy drop not accepted");

  // The offset moves by exactly the accepted energy change.
  a_offset: assert property (@(posedge clk) disable iff (rst)
      m_tvalid |-> m_tdata[OUT_OFS_LSB +: OFFSET_W] == expect_offset)
    else $error("energy offset does not track accepted changes");

  // No result is offered right after reset.
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind ising_metropolis_spin_update_unit imsu_checker u_imsu_checker (.*);

// ===== test/ising_metropolis_spin_update_unit_test.sv =====
// ---------------------------------------------------------------------------
// ising_metropolis_spin_update_unit_test
// Self-checking bench for the Metropolis spin update unit. Load and flip
// attempt items are streamed in with random gaps. Every result item is
// compared field by field against an in-bench lattice predictor.
// ---------------------------------------------------------------------------
module ising_metropolis_spin_update_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import imsu_pkg::*;

  localparam int SIDE   = SIDE_DEFAULT;
  localparam int NSITES = SIDE * SIDE;

  // One expected result item.
  typedef struct {
    logic                       flipped;
    logic signed [DE_W-1:0]     energy_change;
    logic                       spin_after;
    logic signed [OFFSET_W-1:0] energy_offset;
  } spin_result_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LIMIT_W-1:0]   cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  // site[5:0], spin_up[6], bond_down_pos[7], bond_right_pos[8],
  // random_fraction[24:9], zero fill above.
  logic [S_TDATA_W-1:0] s_tdata = '0;
  // kind: 0 load, 1 attempt.
  logic                 s_tuser = KIND_LOAD;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  // flipped[0], energy_change[5:1], spin_after[6], energy_offset[16:7],
  // zero fill above.
  logic [M_TDATA_W-1:0] m_tdata;

  // Predictor state: the lattice as the block should hold it, the running
  // energy offset and the two acceptance thresholds.
  bit                 spin_model [NSITES];
  bit                 down_model [NSITES];
  bit                 right_model[NSITES];
  logic [OFFSET_W-1:0] energy_model = '0;
  logic [LIMIT_W-1:0]  limit4_model = '0;
  logic [LIMIT_W-1:0]  limit8_model = '0;

  // Results predicted for accepted items, oldest first.
  spin_result_t awaited_results[$];

  // When low, neither side inserts idle cycles.
  bit idle_on = 1'b1;

  int fault_count     = 0;
  int loads_sent      = 0;
  int attempts_sent   = 0;
  int flips_predicted = 0;
  int results_checked = 0;
  int settings_used   = 0;

  ising_metropolis_spin_update_unit #(
    .SIDE(SIDE)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs; far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Product of bond, spin and neighbour, each given as a bit with 1 = +1.
  function automatic int bond_term(bit bond, bit spin, bit nbr);
    return (bond ^ spin ^ nbr) ? 1 : -1;
  endfunction

  // Applies one item to the lattice model and returns the result it causes.
  function automatic spin_result_t predict_item(bit attempt, int site, bit spin_up,
                                                bit bdown, bit bright,
                                                logic [FRAC_W-1:0] frac);
    spin_result_t r;
    int row, col, up_i, dn_i, lf_i, rt_i, align, de;
    bit s, take;
    r.flipped       = 1'b0;
    r.energy_change = '0;
    r.spin_after    = 1'b0;
    r.energy_offset = energy_model;
    if (site < NSITES) begin
      if (!attempt) begin
        spin_model[site]  = spin_up;
        down_model[site]  = bdown;
        right_model[site] = bright;
        loads_sent++;
      end else begin
        attempts_sent++;
        row  = site / SIDE;
        col  = site % SIDE;
        // Torus wrap on both axes; the bond to the row above belongs to
        // that site, as does the bond from the left neighbour.
        up_i = ((row + SIDE - 1) % SIDE) * SIDE + col;
        dn_i = ((row + 1) % SIDE) * SIDE + col;
        lf_i = row * SIDE + (col + SIDE - 1) % SIDE;
        rt_i = row * SIDE + (col + 1) % SIDE;
        s    = spin_model[site];
        align = bond_term(down_model[up_i], s, spin_model[up_i])
              + bond_term(down_model[site], s, spin_model[dn_i])
              + bond_term(right_model[lf_i], s, spin_model[lf_i])
              + bond_term(right_model[site], s, spin_model[rt_i]);
        de = -2 * align;
        if (de <= 0) begin
          take = 1'b1;
        end else if (de == DE_RISE_SMALL) begin
          take = (frac <= limit4_model);
        end else begin
          take = (frac <= limit8_model);
        end
        if (take) begin
          spin_model[site] = ~s;
          energy_model     = energy_model + de[OFFSET_W-1:0];
          flips_predicted++;
        end
        r.flipped       = take;
        r.energy_change = de[DE_W-1:0];
      end
      r.spin_after    = spin_model[site];
      r.energy_offset = energy_model;
    end
    return r;
  endfunction

  task automatic log_fault(string what);
    fault_count++;
    if (fault_count <= 10) begin
      $display("%0t ns: %s", $time, what);
    end
  endtask

  // Presents one item and holds it until the block takes it. The valid is
  // left high on return so a following item goes out back to back.
  task automatic send_item(bit attempt, int site, bit spin_up, bit bdown, bit bright,
                           logic [FRAC_W-1:0] frac);
    logic [S_TDATA_W-1:0] word;
    word = '0;
    word[IN_SITE_LSB +: SITE_W] = site[SITE_W-1:0];
    word[IN_SPIN_BIT]           = spin_up;
    word[IN_BDOWN_BIT]          = bdown;
    word[IN_BRIGHT_BIT]         = bright;
    word[IN_FRAC_LSB +: FRAC_W] = frac;
    while (idle_on && $urandom_range(99) < 24) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    s_tuser  <= attempt ? KIND_ATTEMPT : KIND_LOAD;
    do @(posedge clk); while (!s_tready);
    awaited_results.push_back(predict_item(attempt, site, spin_up, bdown, bright, frac));
  endtask

  // Drops the valid and waits until every predicted result has come back.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // Writes both thresholds back to back; only called with the block idle.
  task automatic set_limits(logic [LIMIT_W-1:0] lim4, logic [LIMIT_W-1:0] lim8);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LIMIT_DE4;
    cfg_data  <= lim4;
    @(posedge clk);
    cfg_index <= CFG_LIMIT_DE8;
    cfg_data  <= lim8;
    @(posedge clk);
    cfg_we       <= 1'b0;
    limit4_model  = lim4;
    limit8_model  = lim8;
    settings_used++;
  endtask

  // Fractions cluster on the thresholds so the <= boundary is hit often.
  function automatic logic [FRAC_W-1:0] pick_fraction();
    logic [FRAC_W-1:0] lim;
    lim = $urandom_range(1) ? limit4_model : limit8_model;
    case ($urandom_range(7))
      0: begin
        return '0;
      end
      1: begin
        return '1;
      end
      2: begin
        return lim;
      end
      3: begin
        return lim + 16'd1;
      end
      4: begin
        return lim - 16'd1;
      end
      default: begin
        return FRAC_W'($urandom);
      end
    endcase
  endfunction

  // Directed part: two small clusters around the first and last sites are
  // loaded, then attempts walk through every energy change class with
  // fractions at zero, at full scale and right on each threshold.
  task automatic test_directed();
    int cluster[8] = '{0, 1, 7, 8, 56, 55, 62, 63};
    set_limits(16'h8000, 16'h1000);
    foreach (cluster[i]) begin
      // The last site starts spin down so that its flip costs energy.
      send_item(1'b0, cluster[i], cluster[i] != 63, 1'b1, 1'b1, 16'hFFFF);
    end
    send_item(1'b1, 0, 1'b0, 1'b0, 1'b0, 16'hFFFF);   // fully aligned: falls
    send_item(1'b1, 0, 1'b1, 1'b1, 1'b1, 16'hFFFF);   // rise of eight, above limit
    send_item(1'b1, 0, 1'b0, 1'b1, 1'b0, 16'h1000);   // rise of eight, on limit
    send_item(1'b1, 63, 1'b1, 1'b0, 1'b1, 16'h1001);  // just above limit
    send_item(1'b1, 63, 1'b0, 1'b0, 1'b0, 16'h0000);
    // One anti-aligned neighbour gives changes of four.
    send_item(1'b0, 1, 1'b0, 1'b1, 1'b1, 16'h0000);
    send_item(1'b1, 0, 1'b1, 1'b1, 1'b1, 16'hFFFF);
    send_item(1'b1, 0, 1'b0, 1'b0, 1'b0, 16'h8001);
    send_item(1'b1, 0, 1'b1, 1'b0, 1'b1, 16'h8000);
    // Two anti-aligned neighbours give no change: always accepted.
    send_item(1'b0, 8, 1'b0, 1'b0, 1'b0, 16'h5A5A);
    send_item(1'b1, 0, 1'b0, 1'b0, 1'b0, 16'hFFFF);
    drain_results();
  endtask

  // Random part: the whole lattice is loaded first so that any site may be
  // attempted, then several threshold settings each get a burst of mixed
  // items. One burst runs with no idle cycles on either side.
  task automatic test_random_phases();
    logic [LIMIT_W-1:0] lim4_set[5];
    logic [LIMIT_W-1:0] lim8_set[5];
    lim4_set = '{16'h0000, 16'hFFFF, 16'h8000, LIMIT_W'($urandom), 16'h0001};
    lim8_set = '{16'h0000, 16'hFFFF, 16'h2000, LIMIT_W'($urandom), 16'hFFFE};
    for (int s = 0; s < NSITES; s++) begin
      send_item(1'b0, s, 1'($urandom_range(1)), 1'($urandom_range(1)),
                1'($urandom_range(1)), FRAC_W'($urandom));
    end
    for (int p = 0; p < 5; p++) begin
      drain_results();
      set_limits(lim4_set[p], lim8_set[p]);
      idle_on <= (p != 2);
      repeat (280) begin
        if ($urandom_range(99) < 25) begin
          send_item(1'b0, $urandom_range(NSITES - 1), 1'($urandom_range(1)),
                    1'($urandom_range(1)), 1'($urandom_range(1)), FRAC_W'($urandom));
        end else begin
          // Spin and bond bits are don't-care on an attempt; keep them random.
          send_item(1'b1, $urandom_range(NSITES - 1), 1'($urandom_range(1)),
                    1'($urandom_range(1)), 1'($urandom_range(1)), pick_fraction());
        end
      end
    end
    drain_results();
    idle_on <= 1'b1;
  endtask

  // Reloading a site into full alignment before each attempt makes every
  // flip drop the offset by eight; enough rounds force a full wrap of the
  // ten-bit offset whatever value it started from.
  task automatic test_offset_wrap();
    int hood[5] = '{1, 8, 9, 10, 17};
    foreach (hood[i]) begin
      send_item(1'b0, hood[i], 1'b1, 1'b1, 1'b1, FRAC_W'($urandom));
    end
    repeat (130) begin
      send_item(1'b0, 9, 1'b1, 1'b1, 1'b1, FRAC_W'($urandom));
      send_item(1'b1, 9, 1'b0, 1'b0, 1'b0, FRAC_W'($urandom));
    end
    drain_results();
  endtask

  // Result side back-pressure.
  always @(posedge clk) begin
    m_tready <= !idle_on || ($urandom_range(99) >= 24);
  end

  // Every accepted result is matched against the oldest prediction.
  always @(posedge clk) begin : check_results
    spin_result_t       want;
    logic               got_flip;
    logic [DE_W-1:0]    got_de;
    logic               got_spin;
    logic [OFFSET_W-1:0] got_ofs;
    if (!rst && m_tvalid && m_tready) begin
      got_flip = m_tdata[OUT_FLIP_BIT];
      got_de   = m_tdata[OUT_DE_LSB +: DE_W];
      got_spin = m_tdata[OUT_SPIN_BIT];
      got_ofs  = m_tdata[OUT_OFS_LSB +: OFFSET_W];
      if (awaited_results.size() == 0) begin
        log_fault($sformatf("result item with nothing outstanding, m_tdata=%h", m_tdata));
      end else begin
        want = awaited_results.pop_front();
        results_checked++;
        if (got_flip !== want.flipped || got_de !== want.energy_change ||
            got_spin !== want.spin_after || got_ofs !== want.energy_offset) begin
          log_fault({
            $sformatf("result %0d: expected flip=%0d dE=%0d spin=%0d offset=%0d, ",
                      results_checked, want.flipped, want.energy_change,
                      want.spin_after, want.energy_offset),
            $sformatf("got flip=%0d dE=%0d spin=%0d offset=%0d",
                      got_flip, $signed(got_de), got_spin, $signed(got_ofs))});
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_phases();
    test_offset_wrap();
    drain_results();
    // Let any stray result show up before closing.
    repeat (20) @(posedge clk);
    if (awaited_results.size() != 0) begin
      log_fault($sformatf("%0d results never arrived", awaited_results.size()));
    end
    $display("run covered %0d loads and %0d flip attempts, %0d of them accepted,",
             loads_sent, attempts_sent, flips_predicted);
    $display("%0d result items compared under %0d threshold settings, %0d faults",
             results_checked, settings_used, fault_count);
    if (fault_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
